// ===== hdl/drcr_pkg.sv =====
// shared types, field widths and codes of the replacement-policy block
package drcr_pkg;

  // field widths of the transfer payloads
  localparam int SET_IN_W   = 11;
  localparam int WAY_IN_W   = 4;
  localparam int VICTIM_W   = 4;
  localparam int PSEL_OUT_W = 10;

  // re-reference prediction values
  localparam int          RRPV_W    = 2;
  localparam logic [1:0]  RRPV_FAR  = 2'd3;
  localparam logic [1:0]  RRPV_LONG = 2'd2;
  localparam logic [1:0]  RRPV_HIT  = 2'd0;

  // operation codes
  localparam logic OP_QUERY  = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef struct packed {
    logic                operation;
    logic [SET_IN_W-1:0] set_index;
    logic [WAY_IN_W-1:0] way_index;
    logic                hit_flag;
    logic                had_victim;
  } in_item_t;

  typedef struct packed {
    logic [VICTIM_W-1:0]   victim_way;
    logic                  used_lip;
    logic [PSEL_OUT_W-1:0] psel_value;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } drcr_state_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic capture;
    logic read;
    logic commit;
  } drcr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
  } drcr_sts_t;

endpackage

// ===== hdl/drcr_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
module drcr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/drcr_ctrl.sv =====
// sequencing state machine: clearing pass, capture, row read, execute
module drcr_ctrl import drcr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output drcr_cmd_t cmd,
  input  drcr_sts_t sts
);

  drcr_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  // state and result-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read  = 1'b1;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        // hold until the result register is free
        if (!out_valid_r || !out_stall) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // result register occupancy
  always_comb begin
    priority if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== hdl/drcr_dpath.sv =====
// datapath: set reduction, rrpv row store, victim search, update and psel
module drcr_dpath import drcr_pkg::*; #(
  parameter int NUM_SETS    = 2048,
  parameter int NUM_WAYS    = 16,
  parameter int LEADER_SETS = 64,
  parameter int PSEL_BITS   = 10,
  parameter int BIP_PERIOD  = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  drcr_cmd_t cmd,
  output drcr_sts_t sts,
  input  in_item_t  in_data,
  output out_item_t out_data
);

  localparam int SET_W     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_SEL_W = $clog2(NUM_WAYS);
  localparam int WC_W      = ($clog2(NUM_WAYS + 1) > WAY_IN_W) ? $clog2(NUM_WAYS + 1) : WAY_IN_W;
  localparam int ROW_W     = RRPV_W * NUM_WAYS;
  localparam int CNT_W     = $clog2(BIP_PERIOD);
  localparam int PSEL_MAX  = (1 << PSEL_BITS) - 1;
  localparam int PSEL_HALF = PSEL_MAX / 2;
  // reciprocal for the set reduction: estimate is exact or one low
  localparam int RED_K     = 27;
  localparam int RED_M     = (1 << RED_K) / NUM_SETS;
  localparam int RED_MW    = $clog2(RED_M + 1);
  localparam int PROD_W    = SET_IN_W + RED_MW;

  in_item_t             in_r;
  logic [SET_IN_W-1:0]  q_r;
  logic [SET_W-1:0]     set_r;
  logic [SET_W-1:0]     clr_addr_r;
  logic [PSEL_BITS-1:0] psel_r, psel_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_inc;
  out_item_t            out_r;

  logic [PROD_W-1:0]    prod;
  logic [SET_IN_W-1:0]  q_nxt;
  logic [31:0]          qn;
  logic [31:0]          rem0;
  logic [SET_W-1:0]     set_red;

  logic [ROW_W-1:0]     row_rd, row_aged, row_upd, row_wr;
  logic                 far_any, long_any;
  logic [WAY_SEL_W-1:0] vic_far, vic_long, victim;
  logic                 is_update, miss_upd, lip_lead, bip_lead, use_lip, way_ok;
  logic [RRPV_W-1:0]    ins_val, new_val;
  logic [WC_W-1:0]      way_ext;
  out_item_t            res;

  // quotient estimate of the incoming set index
  assign prod  = PROD_W'(in_data.set_index) * PROD_W'(RED_M);
  assign q_nxt = SET_IN_W'(prod >> RED_K);

  // remainder with one correction step
  always_comb begin
    qn      = 32'(q_r) * 32'(NUM_SETS);
    rem0    = 32'(in_r.set_index) - qn;
    set_red = (rem0 >= 32'(NUM_SETS)) ? SET_W'(rem0 - 32'(NUM_SETS)) : SET_W'(rem0);
  end

  // rrpv row store
  drcr_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_rows (
    .clk   (clk),
    .we    (cmd.clear | cmd.commit),
    .waddr (cmd.clear ? clr_addr_r : set_r),
    .wdata (cmd.clear ? {ROW_W{1'b1}} : row_wr),
    .re    (cmd.read),
    .raddr (set_red),
    .rdata (row_rd)
  );

  // victim search, ageing and update of the fetched row
  always_comb begin
    far_any  = 1'b0;
    long_any = 1'b0;
    vic_far  = '0;
    vic_long = '0;
    // scan downwards so the lowest matching way wins
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (row_rd[w*RRPV_W +: RRPV_W] == RRPV_FAR) begin
        far_any = 1'b1;
        vic_far = WAY_SEL_W'(w);
      end
      if (row_rd[w*RRPV_W +: RRPV_W] == RRPV_LONG) begin
        long_any = 1'b1;
        vic_long = WAY_SEL_W'(w);
      end
    end
    // after one ageing step the long ways are the distant ones
    victim = far_any ? vic_far : (long_any ? vic_long : '0);
    for (int w = 0; w < NUM_WAYS; w++) begin
      row_aged[w*RRPV_W +: RRPV_W] = row_rd[w*RRPV_W +: RRPV_W] + RRPV_W'(1);
    end

    is_update = (in_r.operation == OP_UPDATE);
    miss_upd  = is_update && !in_r.hit_flag;
    cnt_inc   = (32'(cnt_r) + 32'd1 >= 32'(BIP_PERIOD)) ? '0 : cnt_r + CNT_W'(1);
    lip_lead  = 32'(set_r) < 32'(LEADER_SETS / 2);
    bip_lead  = !lip_lead && (32'(set_r) < 32'(LEADER_SETS));
    use_lip   = lip_lead || (!bip_lead && (32'(psel_r) >= 32'(PSEL_HALF)));
    ins_val   = (use_lip || (cnt_inc != '0)) ? RRPV_FAR : RRPV_HIT;
    new_val   = in_r.hit_flag ? RRPV_HIT : ins_val;

    way_ext = WC_W'(in_r.way_index);
    way_ok  = way_ext < WC_W'(NUM_WAYS);
    row_upd = row_rd;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (way_ok && (way_ext == WC_W'(w))) begin
        row_upd[w*RRPV_W +: RRPV_W] = new_val;
      end
    end
    row_wr = is_update ? row_upd : (far_any ? row_rd : row_aged);

    // set dueling selector
    psel_nxt = psel_r;
    if (miss_upd && in_r.had_victim) begin
      priority if (lip_lead) begin
        if (psel_r != '0) begin
          psel_nxt = psel_r - PSEL_BITS'(1);
        end
      end else if (bip_lead) begin
        if (psel_r != PSEL_BITS'(PSEL_MAX)) begin
          psel_nxt = psel_r + PSEL_BITS'(1);
        end
      end else begin
        psel_nxt = psel_r;
      end
    end

    res.victim_way = is_update ? '0 : VICTIM_W'(victim);
    res.used_lip   = miss_upd && use_lip;
    res.psel_value = PSEL_OUT_W'(psel_nxt);
  end

  // policy state and clearing counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      psel_r     <= PSEL_BITS'(PSEL_HALF);
      cnt_r      <= '0;
      clr_addr_r <= '0;
    end else begin
      if (cmd.clear) begin
        clr_addr_r <= clr_addr_r + SET_W'(1);
      end
      if (cmd.commit) begin
        psel_r <= psel_nxt;
        if (is_update) begin
          cnt_r <= cnt_inc;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_r <= in_data;
      q_r  <= q_nxt;
    end
    if (cmd.read) begin
      set_r <= set_red;
    end
    if (cmd.commit) begin
      out_r <= res;
    end
  end

  assign sts.clear_last = (clr_addr_r == SET_W'(NUM_SETS - 1));
  assign out_data       = out_r;

endmodule

// ===== hdl/dip_rrip_cache_replacement_top.sv =====
// top level of the set-dueling rrip replacement-policy block
// Replacement policy for a set-associative cache with a 2-bit RRPV per way and
// set dueling between LIP and BIP insertion. Each item is either a victim query
// or a state update for one set, and gives exactly one result. One item is
// handled at a time, in a capture, a read and an execute step. The capture step
// registers the item together with its set quotient estimate; the read step
// reduces the set index and reads that set's RRPV row from the single-read-port
// row memory; the execute step searches, ages or updates the row, writes it
// back and loads the result register. The block takes no new item until the
// previous one has finished its execute step; a new item is taken while the
// previous result still waits for its transfer, and it then holds in its last
// step until the result register is free.
// After reset the block runs a clearing pass over the row memory, one row per
// cycle, during which in_stall stays high.
module dip_rrip_cache_replacement_top import drcr_pkg::*; #(
  parameter int NUM_SETS    = 2048,
  parameter int NUM_WAYS    = 16,
  parameter int LEADER_SETS = 64,
  parameter int PSEL_BITS   = 10,
  parameter int BIP_PERIOD  = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  drcr_cmd_t cmd;
  drcr_sts_t sts;

  // sequencing
  drcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // row store and policy arithmetic
  drcr_dpath #(
    .NUM_SETS    (NUM_SETS),
    .NUM_WAYS    (NUM_WAYS),
    .LEADER_SETS (LEADER_SETS),
    .PSEL_BITS   (PSEL_BITS),
    .BIP_PERIOD  (BIP_PERIOD)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

// ===== hdl/drcr_checker.sv =====
// port-level checker for the replacement-policy block and its bind
module drcr_checker import drcr_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a waiting result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one item at a time: no new transfer right after one is taken
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in flight");

  // a result never appears in the cycle after an input transfer
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too early");

  // lip insertion only comes from updates, which report way zero
  a_lip_no_victim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.used_lip |-> out_data.victim_way == '0)
    else $error("update result carries a victim way");

endmodule

bind dip_rrip_cache_replacement_top drcr_checker u_drcr_checker (.*);

// ===== sim/tb_dip_rrip_cache_replacement_top.sv =====
// testbench for the set-dueling rrip replacement-policy block
`timescale 1ns / 1ps

module tb_dip_rrip_cache_replacement_top;
  import drcr_pkg::*;

  localparam int IN_W       = $bits(in_item_t);
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_WAIT = 12;

  // keeps the replacement state of the block and the results still owed
  class replacement_scoreboard;
    localparam int SETS        = 2048;
    localparam int WAYS        = 16;
    localparam int LIP_LEADERS = 32;
    localparam int LEADERS     = 64;
    localparam int PSEL_TOP    = 1023;
    localparam int PERIOD      = 32;

    logic [1:0]  rrpv [SETS][WAYS];
    int unsigned psel;
    int unsigned access_count;
    out_item_t   owed_results[$];
    int          mismatches;
    int          results_seen;

    function new();
      foreach (rrpv[s, w]) rrpv[s][w] = RRPV_FAR;
      psel         = PSEL_TOP / 2;
      access_count = 0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    // lowest way at the distant re-reference value, or -1
    function int far_way(int s);
      for (int w = 0; w < WAYS; w++)
        if (rrpv[s][w] == RRPV_FAR) return w;
      return -1;
    endfunction

    // work out the result of one accepted access and update the state
    function void note_access(in_item_t it);
      out_item_t  res;
      int         s;
      int         v;
      bit         way_ok;
      bit         lip_lead;
      bit         bip_lead;
      bit         use_lip;
      logic [1:0] ins;
      res = '0;
      s   = int'(it.set_index) % SETS;
      if (it.operation == OP_QUERY) begin
        v = far_way(s);
        // no distant way: age the whole row once and look again
        if (v < 0) begin
          for (int w = 0; w < WAYS; w++)
            if (rrpv[s][w] < RRPV_FAR) rrpv[s][w] = rrpv[s][w] + 2'd1;
          v = far_way(s);
          if (v < 0) v = 0;
        end
        res.victim_way = VICTIM_W'(v);
      end else begin
        way_ok       = int'(it.way_index) < WAYS;
        access_count = (access_count + 1 >= PERIOD) ? 0 : access_count + 1;
        if (it.hit_flag) begin
          if (way_ok) rrpv[s][it.way_index] = RRPV_HIT;
        end else begin
          lip_lead = s < LIP_LEADERS;
          bip_lead = !lip_lead && s < LEADERS;
          if (lip_lead)      use_lip = 1'b1;
          else if (bip_lead) use_lip = 1'b0;
          else               use_lip = psel >= PSEL_TOP / 2;
          // bimodal insertion lands near only when the access count wraps
          if (use_lip) ins = RRPV_FAR;
          else         ins = (access_count == 0) ? RRPV_HIT : RRPV_FAR;
          if (way_ok) rrpv[s][it.way_index] = ins;
          res.used_lip = use_lip;
          if (it.had_victim) begin
            if (lip_lead && psel > 0) psel--;
            else if (bip_lead && psel < PSEL_TOP) psel++;
          end
        end
      end
      res.psel_value = PSEL_OUT_W'(psel);
      owed_results.push_back(res);
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("mismatch at result %0d: %s got %0d want %0d", results_seen, what, got, want);
      mismatches++;
    endtask

    // compare an accepted result with the oldest one owed
    task check_outcome(out_item_t got);
      out_item_t want;
      if (owed_results.size() == 0) begin
        report_mismatch("unexpected result, victim_way", int'(got.victim_way), 0);
      end else begin
        want = owed_results.pop_front();
        if (got.victim_way !== want.victim_way)
          report_mismatch("victim_way", int'(got.victim_way), int'(want.victim_way));
        if (got.used_lip !== want.used_lip)
          report_mismatch("used_lip", int'(got.used_lip), int'(want.used_lip));
        if (got.psel_value !== want.psel_value)
          report_mismatch("psel_value", int'(got.psel_value), int'(want.psel_value));
      end
      results_seen++;
    endtask
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  replacement_scoreboard tracker = new();

  int burst_left  = 0;
  int sent        = 0;
  int idle_cycles = 0;
  int stall_pct   = 0;
  int stall_left  = 0;
  int pool_sets [8] = '{0, 31, 32, 63, 64, 1024, 2047, 100};

  dip_rrip_cache_replacement_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial forever #4 clk = ~clk;

  // receiver stalls: segments with no stall, light stall and heavy stall
  always @(posedge clk) begin
    if (stall_left == 0) begin
      case ($urandom_range(2))
        0: stall_pct <= 0;
        1: stall_pct <= 25;
        default: stall_pct <= 65;
      endcase
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // result side: check each transfer
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
      tracker.check_outcome(out_data);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("** dip_rrip_cache_replacement_top: FAILED **");
      $finish;
    end
  end

  // random single bit
  function automatic logic coin();
    return 1'($urandom_range(1));
  endfunction

  // drive one item, idling between bursts, and wait for its transfer
  task automatic send_item(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    tracker.note_access(it);
    burst_left--;
    sent++;
  endtask

  task automatic send_fields(input logic op, input int s, input int w, input logic hit,
                             input logic vic);
    in_item_t it;
    it.operation  = op;
    it.set_index  = SET_IN_W'(s);
    it.way_index  = WAY_IN_W'(w);
    it.hit_flag   = hit;
    it.had_victim = vic;
    send_item(it);
  endtask

  // hold the sender back until every owed result has arrived
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  // one random step; bias steers evicting misses to lip (1) or bip (2) leaders
  task automatic random_step(input int bias);
    in_item_t it;
    int       r;
    int       s;
    int       w;
    it = IN_W'($urandom);
    s  = pool_sets[$urandom_range(7)];
    r  = $urandom_range(99);
    if (bias != 0 && r < 70) begin
      send_fields(OP_UPDATE, (bias == 1) ? $urandom_range(0, 31) : $urandom_range(32, 63),
                  $urandom_range(15), 1'b0, 1'b1);
    end else begin
      r = $urandom_range(99);
      if (r < 10) begin
        // hit every way of a set, then query it: ageing without a distant way
        for (w = 0; w < 16; w++)
          send_fields(OP_UPDATE, s, w, 1'b1, coin());
        send_fields(OP_QUERY, s, $urandom_range(15), coin(), coin());
      end else if (r < 40) begin
        send_fields(OP_QUERY, s, $urandom_range(15), coin(), coin());
      end else if (r < 65) begin
        send_fields(OP_UPDATE, s, $urandom_range(15), 1'b1, coin());
      end else if (r < 85) begin
        send_fields(OP_UPDATE, s, $urandom_range(15), 1'b0, coin());
      end else begin
        send_item(it);
      end
    end
  endtask

  initial begin
    pool_sets[7] = $urandom_range(65, 2046);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty set, hit, leaders of both kinds, followers, extreme sets
    send_fields(OP_QUERY,  0,    0,  1'b0, 1'b0);
    send_fields(OP_UPDATE, 0,    0,  1'b1, 1'b0);
    send_fields(OP_QUERY,  0,    15, 1'b1, 1'b1);
    send_fields(OP_UPDATE, 0,    15, 1'b0, 1'b1);
    send_fields(OP_UPDATE, 31,   3,  1'b0, 1'b1);
    send_fields(OP_UPDATE, 32,   0,  1'b0, 1'b1);
    send_fields(OP_UPDATE, 63,   15, 1'b0, 1'b1);
    send_fields(OP_UPDATE, 1,    7,  1'b0, 1'b0);
    send_fields(OP_UPDATE, 33,   7,  1'b0, 1'b0);
    send_fields(OP_UPDATE, 64,   9,  1'b0, 1'b1);
    send_fields(OP_UPDATE, 2047, 0,  1'b0, 1'b1);
    send_fields(OP_UPDATE, 2047, 15, 1'b1, 1'b0);
    send_fields(OP_QUERY,  2047, 0,  1'b0, 1'b0);
    send_fields(OP_QUERY,  1024, 15, 1'b1, 1'b1);
    send_fields(OP_UPDATE, 0,    1,  1'b1, 1'b1);
    send_fields(OP_UPDATE, 32,   1,  1'b1, 1'b1);
    send_fields(OP_QUERY,  0,    0,  1'b0, 1'b0);
    drain_results();

    // mixed traffic on a pool of sets
    while (sent < 250) random_step(0);

    // lip leaders evict until the selector bottoms out, then a little more
    while (tracker.psel != 0 && sent < 1400) random_step(1);
    repeat (30) random_step(1);
    drain_results();

    // bip leaders pull the selector back up
    while (sent < 1550) random_step(2);

    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (tracker.mismatches == 0)
      $display("** dip_rrip_cache_replacement_top: PASSED **");
    else
      $display("** dip_rrip_cache_replacement_top: FAILED **");
    $finish;
  end

endmodule
